FILE: hdl/i2cram_pkg.sv
package i2cram_pkg;

    localparam int unsigned InWidth  = 32;
    localparam int unsigned OutWidth = 16;

    typedef struct packed {
        logic       sda_level;
        logic [7:0] write_data;
        logic [7:0] register_address;
        logic [7:0] device_address;
        logic       operation;
        logic       start_request;
    } t_tick;

    typedef struct packed {
        logic       ack_error;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive_low;
        logic       scl_level;
    } t_res;

    localparam logic [0:0] CfgAckTimeout = 1'b0;
    localparam logic [0:0] CfgRecovery   = 1'b1;

endpackage

FILE: hdl/i2cram_front.sv
module i2cram_front
    import i2cram_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tvalid,
    output logic                o_tready,
    input  logic [InWidth-1:0]  i_tdata,
    output logic                o_valid,
    input  logic                i_ready,
    output t_tick               o_tick
);

    // two-entry queue
    t_tick      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_tick      n_tick;

    always_comb begin
        n_tick.start_request    = i_tdata[0];
        n_tick.operation        = i_tdata[1];
        n_tick.device_address   = i_tdata[9:2];
        n_tick.register_address = i_tdata[17:10];
        n_tick.write_data       = i_tdata[25:18];
        n_tick.sda_level        = i_tdata[26];
    end

    assign o_tready = (r_cnt != 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_tick   = r_q[r_rp];
    assign push     = i_tvalid && o_tready;
    assign pop      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_tick;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: hdl/i2cram_back.sv
module i2cram_back
    import i2cram_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_tick       i_tick,
    output logic        o_tvalid,
    input  logic        i_tready,
    output t_res        o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_ST_A, S_ST_B, S_TX_LO, S_TX_HI, S_TX_LO2, S_ACK_LO, S_ACK_HI,
        S_ACK_WAIT, S_RX_LO, S_RX_HI, S_NACK_LO, S_NACK_HI, S_SP_A, S_SP_B, S_RECOV
    } t_phase;

    t_phase     r_phase, ph, n_phase;
    logic [7:0] r_ato, r_rec;
    logic [3:0] r_bit, n_bit, bi;
    logic [7:0] r_sh, n_sh, sh;
    logic [7:0] r_tc, n_tc, tc;
    logic [7:0] r_dev, r_reg, r_dat, n_dev, n_reg, n_dat;
    logic       r_op, n_op, r_err, n_err;
    logic [7:0] r_cap, n_cap;
    logic [1:0] r_stg, n_stg, stg;
    logic       r_ov, take;
    t_res       r_res, n_res;
    logic       seg_end;
    logic [7:0] seg_len, nxt_byte;

    assign o_ready  = !r_ov || i_tready;
    assign take     = i_valid && o_ready;
    assign o_tvalid = r_ov;
    assign o_res    = r_res;

    always_comb begin
        ph = r_phase; tc = r_tc; bi = r_bit; stg = r_stg;
        n_dev = r_dev; n_reg = r_reg; n_dat = r_dat; n_op = r_op; n_err = r_err;
        n_cap = r_cap;
        if (r_phase == S_IDLE && i_tick.start_request) begin
            n_op = i_tick.operation; n_dev = i_tick.device_address;
            n_reg = i_tick.register_address; n_dat = i_tick.write_data;
            n_err = 1'b0; stg = 2'd0; bi = 4'd0; tc = 8'd0; ph = S_ST_A;
        end
        sh = r_sh;
        n_res.scl_level = 1'b1; n_res.sda_drive_low = 1'b0; n_res.done_res = 1'b0;
        unique case (ph)
            S_ST_B: n_res.sda_drive_low = 1'b1;
            S_TX_LO, S_TX_LO2: begin
                n_res.scl_level = 1'b0; n_res.sda_drive_low = !sh[7];
            end
            S_TX_HI: n_res.sda_drive_low = !sh[7];
            S_ACK_LO, S_RX_LO, S_NACK_LO: n_res.scl_level = 1'b0;
            S_SP_A: begin n_res.scl_level = 1'b0; n_res.sda_drive_low = 1'b1; end
            default: ;
        endcase
        n_res.busy_res = (ph != S_IDLE);
        unique case (ph)
            S_ST_A, S_ST_B, S_SP_A, S_SP_B: seg_len = 8'd4;
            S_TX_LO, S_TX_HI, S_TX_LO2, S_RX_LO, S_NACK_LO, S_NACK_HI: seg_len = 8'd2;
            S_RECOV: seg_len = r_rec;
            default: seg_len = 8'd1;
        endcase
        seg_end = ({1'b0, tc} + 9'd1) >= {1'b0, seg_len};
        n_phase = ph; n_tc = tc; n_bit = bi; n_sh = sh; n_stg = stg;
        // byte for the next send, given the stage it is for
        nxt_byte = r_dat;
        if (ph != S_IDLE) begin
            if (ph == S_ACK_WAIT) begin
                if (!i_tick.sda_level) begin
                    n_tc = 8'd0;
                    if (!n_op && stg >= 2'd2) n_phase = S_SP_A;
                    else if (n_op && stg == 2'd1) begin
                        n_stg = 2'd2; n_phase = S_ST_A;
                    end else if (n_op && stg == 2'd2) begin
                        n_stg = 2'd3; n_bit = 4'd0; n_sh = 8'd0; n_phase = S_RX_LO;
                    end else begin
                        n_stg = stg + 2'd1;
                        if (n_stg == 2'd1) nxt_byte = n_reg;
                        else if (n_op) nxt_byte = n_dev + 8'd1;
                        else nxt_byte = n_dat;
                        n_sh = nxt_byte; n_bit = 4'd0; n_phase = S_TX_LO;
                    end
                end else if ({1'b0, tc} + 9'd1 > {1'b0, r_ato}) begin
                    n_err = 1'b1; n_tc = 8'd0; n_phase = S_SP_A;
                end else n_tc = tc + 8'd1;
            end else if (!seg_end) begin
                n_tc = tc + 8'd1;
            end else begin
                n_tc = 8'd0;
                unique case (ph)
                    S_ST_A: n_phase = S_ST_B;
                    S_ST_B: begin
                        if (stg == 2'd0) nxt_byte = n_dev;
                        else if (stg == 2'd1) nxt_byte = n_reg;
                        else if (n_op) nxt_byte = n_dev + 8'd1;
                        n_sh = nxt_byte; n_bit = 4'd0; n_phase = S_TX_LO;
                    end
                    S_TX_LO: n_phase = S_TX_HI;
                    S_TX_HI: n_phase = S_TX_LO2;
                    S_TX_LO2: begin
                        n_sh = {sh[6:0], 1'b0}; n_bit = bi + 4'd1;
                        n_phase = (n_bit >= 4'd8) ? S_ACK_LO : S_TX_LO;
                    end
                    S_ACK_LO: n_phase = S_ACK_HI;
                    S_ACK_HI: n_phase = S_ACK_WAIT;
                    S_RX_LO: n_phase = S_RX_HI;
                    S_RX_HI: begin
                        n_sh = {sh[6:0], i_tick.sda_level}; n_bit = bi + 4'd1;
                        if (n_bit >= 4'd8) begin
                            n_cap = n_sh; n_phase = S_NACK_LO;
                        end else n_phase = S_RX_LO;
                    end
                    S_NACK_LO: n_phase = S_NACK_HI;
                    S_NACK_HI: n_phase = S_SP_A;
                    S_SP_A: n_phase = S_SP_B;
                    S_SP_B: begin
                        if (!n_op && !n_err && r_rec != 8'd0) n_phase = S_RECOV;
                        else begin n_phase = S_IDLE; n_res.done_res = 1'b1; end
                    end
                    default: begin n_phase = S_IDLE; n_res.done_res = 1'b1; end
                endcase
            end
        end
        n_res.read_data = n_cap;
        n_res.ack_error = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (take) r_res <= n_res;
        if (!i_rst_n) begin
            r_phase <= S_IDLE; r_bit <= 4'd0; r_sh <= 8'd0; r_tc <= 8'd0;
            r_dev <= 8'd0; r_reg <= 8'd0; r_dat <= 8'd0; r_op <= 1'b0;
            r_cap <= 8'd0; r_err <= 1'b0; r_stg <= 2'd0; r_ov <= 1'b0;
            r_ato <= 8'd250; r_rec <= 8'd200;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgAckTimeout: r_ato <= i_cfg_data;
                    CfgRecovery:   r_rec <= i_cfg_data;
                    default: ;
                endcase
            end
            if (take) begin
                r_phase <= n_phase; r_bit <= n_bit; r_sh <= n_sh; r_tc <= n_tc;
                r_dev <= n_dev; r_reg <= n_reg; r_dat <= n_dat; r_op <= n_op;
                r_cap <= n_cap; r_err <= n_err; r_stg <= n_stg;
            end
            if (take) r_ov <= 1'b1;
            else if (i_tready) r_ov <= 1'b0;
        end
    end

endmodule

FILE: hdl/i2c_register_access_master_unit.sv
// I2C register access master, one tick per request.
// Slave stream: s_axis_tdata carries one tick request (bus level sample and an
// optional transaction start). Master stream: m_axis_tdata carries the SCL
// level, SDA pull-down and status for that same tick.
// Config: i_cfg_we/i_cfg_index/i_cfg_data; index 0 ack timeout, 1 write recovery.
// A two-entry queue feeds the bit engine, which handles one tick per cycle while
// the master side is not stalled; its result register is the output stage. An
// accepted tick is registered in the queue and then in the result register.
// Reset: engine idle, timeout 250, recovery 200, queue and result register empty.
// A stalled master side holds the result; the queue then fills and tready drops.
module i2c_register_access_master_unit
    import i2cram_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // start_request, operation, device_address, register_address, write_data, sda_level
    input  logic [InWidth-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // scl_level, sda_drive_low, busy_res, done_res, read_data, ack_error
    output logic [OutWidth-1:0] m_axis_tdata
);

    logic  q_valid, q_ready;
    t_tick q_tick;
    t_res  res;

    i2cram_front u_front (
        .i_clk, .i_rst_n,
        .i_tvalid(s_axis_tvalid), .o_tready(s_axis_tready), .i_tdata(s_axis_tdata),
        .o_valid(q_valid), .i_ready(q_ready), .o_tick(q_tick)
    );

    i2cram_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid(q_valid), .o_ready(q_ready), .i_tick(q_tick),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {3'b000, res.ack_error, res.read_data, res.done_res,
                           res.busy_res, res.sda_drive_low, res.scl_level};

endmodule

FILE: hdl/i2cram_checker.sv
module i2cram_checker
    import i2cram_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutWidth-1:0] m_axis_tdata
);

    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[0] && !m_axis_tdata[1])
        else $error("idle bus not released");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
        else $error("done without busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind i2c_register_access_master_unit i2cram_checker u_checker (.*);
